FILE: design/crm_pkg.sv
// Shared package of the compression rate monitor.
// Holds the window sizing, the divider sizing, codes, state and the structs
// that join the controller and the datapath. Depends on nothing.
package crm_pkg;

	localparam int WINDOW = 4;
	localparam int HEAD_W = $clog2(WINDOW);
	localparam int DVS_W = $clog2(WINDOW + 1);
	localparam int SUM_W = 32 + HEAD_W + 1;
	localparam int DIV_BITS = 5;
	localparam int DIV_STEPS = (SUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_W = DIV_STEPS * DIV_BITS;
	localparam int STEP_W = $clog2(DIV_STEPS + 1);
	localparam int ADDR_W = 4;

	localparam logic [1:0] REG_SLOW = 2'd0;
	localparam logic [1:0] REG_FAST = 2'd1;
	localparam logic [1:0] REG_PRESSES = 2'd2;

	localparam logic [15:0] SLOW_RESET = 16'd750;
	localparam logic [15:0] FAST_RESET = 16'd350;
	localparam logic [7:0] PRESSES_RESET = 8'd30;

	typedef enum logic [2:0] {
		STAT_GOOD = 3'd0,
		STAT_SLOW = 3'd1,
		STAT_FAST = 3'd2,
		STAT_VENT = 3'd3,
		STAT_RESTART = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_PREP,
		S_DIVIDE,
		S_UPDATE,
		S_OUTPUT
	} state_t;

	typedef struct packed {
		logic [15:0] slow;
		logic [15:0] fast;
		logic [7:0] presses;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic restart;
		logic interval;
		logic grow;
		logic slide;
		logic div_store;
		logic update;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic restart_req;
		logic grow_sel;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

FILE: design/crm_apb_regs.sv
// Configuration registers of the compression rate monitor behind an APB port.
// Depends on crm_pkg for register codes, reset values and the cfg_t struct.
module crm_apb_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [crm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output crm_pkg::cfg_t             cfg
);

	crm_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow <= crm_pkg::SLOW_RESET;
			cfg_q.fast <= crm_pkg::FAST_RESET;
			cfg_q.presses <= crm_pkg::PRESSES_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				crm_pkg::REG_SLOW: cfg_q.slow <= pwdata[15:0];
				crm_pkg::REG_FAST: cfg_q.fast <= pwdata[15:0];
				crm_pkg::REG_PRESSES: cfg_q.presses <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			crm_pkg::REG_SLOW: prdata = {16'd0, cfg_q.slow};
			crm_pkg::REG_FAST: prdata = {16'd0, cfg_q.fast};
			crm_pkg::REG_PRESSES: prdata = {24'd0, cfg_q.presses};
			default: prdata = 32'd0;
		endcase
	end

endmodule

FILE: design/crm_div.sv
// Iterative restoring divider for the growing mean, several quotient bits per cycle.
// Depends on crm_pkg for the dividend, divisor and step widths.
module crm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [crm_pkg::DIV_W-1:0] dividend,
	input  logic [crm_pkg::DVS_W-1:0] divisor,
	output logic                      done,
	output logic [31:0]               quotient
);

	logic [crm_pkg::DIV_W-1:0]  work_q;
	logic [crm_pkg::DVS_W-1:0]  rem_q;
	logic [crm_pkg::DVS_W-1:0]  divisor_q;
	logic [crm_pkg::STEP_W-1:0] step_q;
	logic                       busy_q;
	logic                       done_q;
	logic [crm_pkg::DIV_W-1:0]  work_v;
	logic [crm_pkg::DVS_W-1:0]  rem_v;
	logic [crm_pkg::DVS_W:0]    trial;

	assign done = done_q;
	assign quotient = work_q[31:0];

	// Each pass shifts one dividend bit into the remainder and one quotient bit in.
	always_comb begin
		rem_v = rem_q;
		work_v = work_q;
		trial = '0;
		for (int i = 0; i < crm_pkg::DIV_BITS; i++) begin
			trial = {rem_v, work_v[crm_pkg::DIV_W-1]};
			work_v = {work_v[crm_pkg::DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor_q}) begin
				rem_v = crm_pkg::DVS_W'(trial - {1'b0, divisor_q});
				work_v[0] = 1'b1;
			end else begin
				rem_v = trial[crm_pkg::DVS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + crm_pkg::STEP_W'(1);
				if (step_q == crm_pkg::STEP_W'(crm_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			work_q <= work_v;
			rem_q <= rem_v;
		end
	end

endmodule

FILE: design/crm_datapath.sv
// Datapath of the compression rate monitor: timer, interval window, average,
// press count, status and the output register. Depends on crm_pkg and crm_div.
module crm_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crm_pkg::cmd_t        cmd,
	output crm_pkg::stat_t       stat,
	input  crm_pkg::cfg_t        cfg,
	input  logic                 in_kind,
	input  logic [31:0]          in_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           out_status,
	output logic [7:0]           out_count,
	output logic [31:0]          out_avg
);

	logic                       kind_q;
	logic [31:0]                time_q;
	logic [31:0]                window_q [crm_pkg::WINDOW];
	logic [crm_pkg::HEAD_W-1:0] head_q;
	logic [31:0]                origin_q;
	logic                       running_q;
	logic [31:0]                last_q;
	logic [31:0]                avg_q;
	logic [7:0]                 count_q;
	logic                       active_q;
	logic [31:0]                interval_q;
	crm_pkg::status_t           res_status_q;
	logic                       out_valid_q;
	logic [2:0]                 out_status_q;
	logic [7:0]                 out_count_q;
	logic [31:0]                out_avg_q;

	logic [crm_pkg::HEAD_W-1:0] count_small;
	logic [crm_pkg::HEAD_W:0]   idx_sum;
	logic [crm_pkg::HEAD_W-1:0] wr_idx;
	logic [crm_pkg::HEAD_W-1:0] head_next;
	logic [31:0]                offset;
	logic [7:0]                 press_next;
	logic [crm_pkg::DIV_W-1:0]  dividend;
	logic [crm_pkg::DVS_W-1:0]  divisor;
	logic                       div_done;
	logic [31:0]                quotient;

	assign count_small = count_q[crm_pkg::HEAD_W-1:0];
	assign idx_sum = {1'b0, head_q} + {1'b0, count_small};
	assign wr_idx = (idx_sum >= (crm_pkg::HEAD_W+1)'(crm_pkg::WINDOW)) ?
		crm_pkg::HEAD_W'(idx_sum - (crm_pkg::HEAD_W+1)'(crm_pkg::WINDOW)) :
		idx_sum[crm_pkg::HEAD_W-1:0];
	assign head_next = (head_q == crm_pkg::HEAD_W'(crm_pkg::WINDOW - 1)) ?
		'0 : head_q + crm_pkg::HEAD_W'(1);
	assign offset = running_q ? time_q - origin_q : 32'd0;
	assign press_next = count_q + 8'd1;
	assign dividend = crm_pkg::DIV_W'(avg_q) * crm_pkg::DIV_W'(count_small)
		+ crm_pkg::DIV_W'(interval_q);
	assign divisor = crm_pkg::DVS_W'(count_small) + crm_pkg::DVS_W'(1);

	assign stat.restart_req = !kind_q || !active_q;
	assign stat.grow_sel = count_q < 8'(crm_pkg::WINDOW);
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_status = out_status_q;
	assign out_count = out_count_q;
	assign out_avg = out_avg_q;

	crm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.grow),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			origin_q <= '0;
			running_q <= 1'b0;
			last_q <= '0;
			avg_q <= '0;
			count_q <= '0;
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				last_q <= '0;
				avg_q <= '0;
				count_q <= '0;
				active_q <= 1'b1;
				head_q <= '0;
			end
			if (cmd.interval) begin
				if (!running_q) begin
					origin_q <= time_q;
					running_q <= 1'b1;
				end
				last_q <= offset;
			end
			if (cmd.slide) begin
				avg_q <= avg_q - window_q[head_q] / crm_pkg::WINDOW
					+ interval_q / crm_pkg::WINDOW;
				head_q <= head_next;
			end
			if (cmd.div_store) begin
				avg_q <= quotient;
			end
			if (cmd.update) begin
				count_q <= press_next;
				if (press_next >= cfg.presses) begin
					active_q <= 1'b0;
					running_q <= 1'b0;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			time_q <= in_time;
		end
		if (cmd.interval) begin
			interval_q <= offset - last_q;
		end
		if (cmd.grow) begin
			window_q[wr_idx] <= interval_q;
		end
		if (cmd.slide) begin
			window_q[head_q] <= interval_q;
		end
		if (cmd.restart) begin
			res_status_q <= crm_pkg::STAT_RESTART;
		end
		if (cmd.update) begin
			priority if (press_next >= cfg.presses) begin
				res_status_q <= crm_pkg::STAT_VENT;
			end else if (press_next >= 8'(crm_pkg::WINDOW) && avg_q > {16'd0, cfg.slow}) begin
				res_status_q <= crm_pkg::STAT_SLOW;
			end else if (press_next >= 8'(crm_pkg::WINDOW) && avg_q < {16'd0, cfg.fast}) begin
				res_status_q <= crm_pkg::STAT_FAST;
			end else begin
				res_status_q <= crm_pkg::STAT_GOOD;
			end
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_count_q <= count_q;
			out_avg_q <= avg_q;
		end
	end

endmodule

FILE: design/crm_ctrl.sv
// Controller state machine of the compression rate monitor.
// Depends on crm_pkg for the state type and the command and status structs.
module crm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  crm_pkg::stat_t stat,
	output crm_pkg::cmd_t  cmd
);

	crm_pkg::state_t state_q;
	crm_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crm_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			crm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_next = crm_pkg::S_DECODE;
				end
			end
			crm_pkg::S_DECODE: begin
				if (stat.restart_req) begin
					cmd.restart = 1'b1;
					state_next = crm_pkg::S_OUTPUT;
				end else begin
					cmd.interval = 1'b1;
					state_next = crm_pkg::S_PREP;
				end
			end
			crm_pkg::S_PREP: begin
				if (stat.grow_sel) begin
					cmd.grow = 1'b1;
					state_next = crm_pkg::S_DIVIDE;
				end else begin
					cmd.slide = 1'b1;
					state_next = crm_pkg::S_UPDATE;
				end
			end
			crm_pkg::S_DIVIDE: begin
				if (stat.div_done) begin
					cmd.div_store = 1'b1;
					state_next = crm_pkg::S_UPDATE;
				end
			end
			crm_pkg::S_UPDATE: begin
				cmd.update = 1'b1;
				state_next = crm_pkg::S_OUTPUT;
			end
			crm_pkg::S_OUTPUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_next = crm_pkg::S_IDLE;
				end
			end
			default: state_next = crm_pkg::S_IDLE;
		endcase
	end

endmodule

FILE: design/compression_rate_monitor.sv
// Top level of the compression rate monitor.
// Depends on crm_pkg, crm_apb_regs, crm_ctrl and crm_datapath.
//
// Each input word is a start event or a press with its millisecond timestamp, and
// each gives one result word with a status, the press count of the cycle and the
// running average interval. Words are handled one at a time: a start, or a press
// while idle, passes states IDLE, DECODE and OUTPUT; a press with a full window
// also passes PREP and UPDATE, and one while the window is filling waits in DIVIDE
// too, for the divider of the growing mean with seven steps of five quotient bits.
// A finished result waits in the output register, so a new word is taken while the
// previous result is still pending; only a result not taken before the next one is
// ready holds the block. Thresholds and the cycle length must be written through
// the APB port only while no word is in flight; the block does not enforce this.
module compression_rate_monitor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,  // time_ms
	input  logic                       s_tuser,  // kind
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [39:0]                m_tdata,  // average_ms, press_count
	output logic [2:0]                 m_tuser,  // status
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [crm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	crm_pkg::cfg_t  cfg;
	crm_pkg::cmd_t  cmd;
	crm_pkg::stat_t stat;
	logic [7:0]     out_count;
	logic [31:0]    out_avg;

	assign m_tdata = {out_avg, out_count};

	crm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	crm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg        (cfg),
		.in_kind    (s_tuser),
		.in_time    (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_count  (out_count),
		.out_avg    (out_avg)
	);

endmodule
